// ----- rtl/core/psd_pkg.sv -----
// ---------------------------------------------------------------------------
// psd_pkg
// Shared codes and constants for the point to segment distance pipeline.
// ---------------------------------------------------------------------------
package psd_pkg;

  // result field width and saturation value
  localparam int unsigned DIST_W = 18;
  localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;

  // configuration register indexes
  localparam int unsigned CFG_IW = 3;
  typedef logic [CFG_IW-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_END_A_X = 3'd0;
  localparam cfg_idx_t REG_END_A_Y = 3'd1;
  localparam cfg_idx_t REG_END_A_Z = 3'd2;
  localparam cfg_idx_t REG_END_B_X = 3'd3;
  localparam cfg_idx_t REG_END_B_Y = 3'd4;
  localparam cfg_idx_t REG_END_B_Z = 3'd5;
  localparam cfg_idx_t REG_INLIER_LIMIT = 3'd6;

  // projection parameter selection
  typedef logic [1:0] tsel_t;
  localparam tsel_t SEL_ZERO = 2'd0;
  localparam tsel_t SEL_ONE  = 2'd1;
  localparam tsel_t SEL_DIV  = 2'd2;

endpackage

// ----- rtl/core/psd_if.sv -----
// ---------------------------------------------------------------------------
// psd_if
// Valid/ready channels for points, distance results and register writes.
// ---------------------------------------------------------------------------
interface psd_pt_if #(parameter int CW = 16);
  logic          valid;
  logic          ready;
  logic [CW-1:0] px;
  logic [CW-1:0] py;
  logic [CW-1:0] pz;
  modport src (output valid, px, py, pz, input ready);
  modport snk (input valid, px, py, pz, output ready);
endinterface

interface psd_res_if;
  logic        valid;
  logic        ready;
  logic [17:0] seg_distance;
  logic        is_inlier;
  modport src (output valid, seg_distance, is_inlier, input ready);
  modport snk (input valid, seg_distance, is_inlier, output ready);
endinterface

interface psd_cfg_if #(parameter int DW = 18);
  logic          valid;
  logic          ready;
  logic [2:0]    index;
  logic [DW-1:0] data;
  modport src (output valid, index, data, input ready);
  modport snk (input valid, index, data, output ready);
endinterface

// ----- rtl/core/psd_div_cell.sv -----
// ---------------------------------------------------------------------------
// psd_div_cell
// One restoring division step: one quotient bit per cell, payload rides along.
// ---------------------------------------------------------------------------
module psd_div_cell import psd_pkg::*; #(
  parameter int LW = 34,
  parameter int QW = 16,
  parameter int PW = 53
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_vld,
  input  logic [LW-1:0] den_in,
  input  logic [LW-1:0] rem_in,
  input  logic [QW-1:0] q_in,
  input  logic [PW-1:0] pas_in,
  output logic          vld_r,
  output logic [LW-1:0] den_r,
  output logic [LW-1:0] rem_r,
  output logic [QW-1:0] q_r,
  output logic [PW-1:0] pas_r
);

  logic [LW:0]   rem2;
  logic [LW:0]   diff;
  logic          ge;
  logic [LW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;

  // shift in a zero, try to subtract the divisor
  always_comb begin
    rem2    = {rem_in, 1'b0};
    diff    = rem2 - {1'b0, den_in};
    ge      = rem2 >= {1'b0, den_in};
    rem_nxt = ge ? diff[LW-1:0] : rem2[LW-1:0];
    q_nxt   = {q_in[QW-2:0], ge};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      den_r <= den_in;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      pas_r <= pas_in;
    end
  end

endmodule

// ----- rtl/core/psd_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// psd_sqrt_cell
// One digit-by-digit square root step: two radicand bits in, one root bit out.
// ---------------------------------------------------------------------------
module psd_sqrt_cell import psd_pkg::*; #(
  parameter int QW = 36
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  logic [QW+1:0]   rem_in,
  input  logic [QW-1:0]   root_in,
  input  logic [2*QW-1:0] src_in,
  output logic            vld_r,
  output logic [QW+1:0]   rem_r,
  output logic [QW-1:0]   root_r,
  output logic [2*QW-1:0] src_r
);

  logic [QW+3:0]   cur;
  logic [QW+3:0]   trial;
  logic [QW+3:0]   diff;
  logic            ge;
  logic [QW+1:0]   rem_nxt;
  logic [QW-1:0]   root_nxt;
  logic [2*QW-1:0] src_nxt;

  // bring down two bits, test against 4*root + 1
  always_comb begin
    cur      = {rem_in, src_in[2*QW-1 -: 2]};
    trial    = {2'b00, root_in, 2'b01};
    diff     = cur - trial;
    ge       = cur >= trial;
    rem_nxt  = ge ? diff[QW+1:0] : cur[QW+1:0];
    root_nxt = {root_in[QW-2:0], ge};
    src_nxt  = {src_in[2*QW-3:0], 2'b00};
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      src_r  <= src_nxt;
    end
  end

endmodule

// ----- rtl/core/point_segment_distance_3d.sv -----
// Throughput: one point per cycle unless the output stalls; every stage
// holds one request and a stage advances when it is empty or its
// successor advances.
// The division and square root cell rows set the length of the pipe.
// Reset (synchronous, rst_n low) clears all stage valid bits and sets the
// segment ends and the inlier limit to zero.
// ---------------------------------------------------------------------------
// point_segment_distance_3d
// Pipelined distance from streamed 3D points to a configured segment.
// ---------------------------------------------------------------------------
module point_segment_distance_3d import psd_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  psd_pt_if.snk      in_pt,
  psd_res_if.src     out_res,
  psd_cfg_if.snk     cfg_wr
);

  localparam int C   = COORD_WIDTH;
  localparam int T   = T_FRAC_BITS;
  localparam int VW  = C + 1;
  localparam int PRW = 2 * VW;
  localparam int DTW = PRW + 2;
  localparam int LW  = PRW;
  localparam int PW  = 3 * VW + 2;
  localparam int RW  = VW + T + 3;
  localparam int TVW = T + 2 + VW;
  localparam int MW  = RW;
  localparam int KL  = (MW + 1) / 2;
  localparam int KH  = MW - KL;
  localparam int SW  = 2 * MW + 2;
  localparam int QW  = SW / 2;
  localparam int DQ  = QW - T;
  localparam int DXW = (DQ > DIST_W) ? DQ : DIST_W;
  localparam int NS  = 9 + T + QW;

  // configuration registers
  logic signed [C-1:0] a_r [3];
  logic signed [C-1:0] b_r [3];
  logic [DIST_W-1:0]   limit_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        a_r[i] <= '0;
        b_r[i] <= '0;
      end
      limit_r <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_END_A_X:      a_r[0] <= cfg_wr.data[C-1:0];
        REG_END_A_Y:      a_r[1] <= cfg_wr.data[C-1:0];
        REG_END_A_Z:      a_r[2] <= cfg_wr.data[C-1:0];
        REG_END_B_X:      b_r[0] <= cfg_wr.data[C-1:0];
        REG_END_B_Y:      b_r[1] <= cfg_wr.data[C-1:0];
        REG_END_B_Z:      b_r[2] <= cfg_wr.data[C-1:0];
        REG_INLIER_LIMIT: limit_r <= cfg_wr.data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // segment direction; user must keep it stable while requests are in flight
  logic signed [VW-1:0] v [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i] = VW'(b_r[i]) - VW'(a_r[i]);
    end
  end

  // stage valids and advance chain
  logic [NS-1:0] vld_all;
  logic [NS:0]   adv_all;
  logic [3:0]    pre_vld_r;
  logic [3:0]    post_vld_r;
  logic          out_vld_r;
  logic [T:0]    d_vld;
  logic [QW:0]   q_vld;

  assign adv_all[NS] = out_res.ready;
  for (genvar k = 0; k < NS; k++) begin : g_adv
    assign adv_all[k] = !vld_all[k] || adv_all[k+1];
  end

  assign vld_all[3:0] = pre_vld_r;
  assign vld_all[4+T-1:4] = d_vld[T:1];
  assign vld_all[8+T-1:4+T] = post_vld_r;
  assign vld_all[8+T+QW-1:8+T] = q_vld[QW:1];
  assign vld_all[NS-1] = out_vld_r;

  assign in_pt.ready = adv_all[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_vld_r  <= '0;
      post_vld_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (adv_all[0]) pre_vld_r[0] <= in_pt.valid;
      for (int k = 1; k < 4; k++) begin
        if (adv_all[k]) pre_vld_r[k] <= pre_vld_r[k-1];
      end
      if (adv_all[4+T]) post_vld_r[0] <= d_vld[T];
      for (int k = 1; k < 4; k++) begin
        if (adv_all[4+T+k]) post_vld_r[k] <= post_vld_r[k-1];
      end
      if (adv_all[NS-1]) out_vld_r <= q_vld[QW];
    end
  end

  // s0: point relative to first end
  logic signed [VW-1:0] w0_r [3];
  logic signed [C-1:0]  p_in [3];
  assign p_in[0] = in_pt.px;
  assign p_in[1] = in_pt.py;
  assign p_in[2] = in_pt.pz;

  always_ff @(posedge clk) begin
    if (adv_all[0]) begin
      for (int i = 0; i < 3; i++) begin
        w0_r[i] <= VW'(p_in[i]) - VW'(a_r[i]);
      end
    end
  end

  // s1: component products
  logic signed [VW-1:0]  w1_r [3];
  logic signed [PRW-1:0] wv1_r [3];
  logic signed [PRW-1:0] vv1_r [3];

  always_ff @(posedge clk) begin
    if (adv_all[1]) begin
      for (int i = 0; i < 3; i++) begin
        w1_r[i]  <= w0_r[i];
        wv1_r[i] <= w0_r[i] * v[i];
        vv1_r[i] <= v[i] * v[i];
      end
    end
  end

  // s2: dot product and squared length
  logic signed [VW-1:0]  w2_r [3];
  logic signed [DTW-1:0] dot2_r;
  logic [LW-1:0]         len2_r;

  always_ff @(posedge clk) begin
    if (adv_all[2]) begin
      for (int i = 0; i < 3; i++) begin
        w2_r[i] <= w1_r[i];
      end
      dot2_r <= DTW'(wv1_r[0]) + DTW'(wv1_r[1]) + DTW'(wv1_r[2]);
      len2_r <= LW'(vv1_r[0]) + LW'(vv1_r[1]) + LW'(vv1_r[2]);
    end
  end

  // s3: clamp decision and divider setup
  tsel_t         sel_nxt;
  logic [LW-1:0] rem3_r;
  logic [LW-1:0] den3_r;
  logic [PW-1:0] pas3_r;
  tsel_t         sel3_r;

  always_comb begin
    if (len2_r == '0 || dot2_r <= 0) begin
      sel_nxt = SEL_ZERO;
    end else if (dot2_r >= $signed(DTW'({1'b0, len2_r}))) begin
      sel_nxt = SEL_ONE;
    end else begin
      sel_nxt = SEL_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_all[3]) begin
      rem3_r <= (sel_nxt == SEL_DIV) ? dot2_r[LW-1:0] : '0;
      den3_r <= len2_r;
      sel3_r <= sel_nxt;
      pas3_r <= {sel_nxt, w2_r[2], w2_r[1], w2_r[0]};
    end
  end

  // division cell row, one quotient bit per cell
  logic [LW-1:0] d_den [T+1];
  logic [LW-1:0] d_rem [T+1];
  logic [T-1:0]  d_q   [T+1];
  logic [PW-1:0] d_pas [T+1];

  assign d_vld[0] = pre_vld_r[3];
  assign d_den[0] = den3_r;
  assign d_rem[0] = rem3_r;
  assign d_q[0]   = '0;
  assign d_pas[0] = pas3_r;

  for (genvar j = 0; j < T; j++) begin : g_div
    psd_div_cell #(.LW(LW), .QW(T), .PW(PW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv_all[4+j]),
      .in_vld (d_vld[j]),
      .den_in (d_den[j]),
      .rem_in (d_rem[j]),
      .q_in   (d_q[j]),
      .pas_in (d_pas[j]),
      .vld_r  (d_vld[j+1]),
      .den_r  (d_den[j+1]),
      .rem_r  (d_rem[j+1]),
      .q_r    (d_q[j+1]),
      .pas_r  (d_pas[j+1])
    );
  end

  // s4: residual w * 2^T - t * v
  logic [T:0]            t_sel;
  tsel_t                 sel_d;
  logic signed [VW-1:0]  w_d [3];
  logic signed [TVW-1:0] tv [3];
  logic signed [RW-1:0]  wt [3];
  logic signed [RW-1:0]  r4_r [3];

  always_comb begin
    sel_d  = d_pas[T][PW-1 -: 2];
    w_d[0] = d_pas[T][VW-1:0];
    w_d[1] = d_pas[T][2*VW-1:VW];
    w_d[2] = d_pas[T][3*VW-1:2*VW];
    case (sel_d)
      SEL_ONE: t_sel = {1'b1, {T{1'b0}}};
      SEL_DIV: t_sel = {1'b0, d_q[T]};
      default: t_sel = '0;
    endcase
    for (int i = 0; i < 3; i++) begin
      tv[i] = $signed({1'b0, t_sel}) * v[i];
      wt[i] = RW'(w_d[i]) <<< T;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_all[4+T]) begin
      for (int i = 0; i < 3; i++) begin
        r4_r[i] <= wt[i] - RW'(tv[i]);
      end
    end
  end

  // s5: magnitude split into halves, partial products
  logic [MW-1:0]      m5 [3];
  logic [2*KH-1:0]    hh5_r [3];
  logic [KH+KL-1:0]   hl5_r [3];
  logic [2*KL-1:0]    ll5_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m5[i] = r4_r[i][RW-1] ? MW'(-r4_r[i]) : MW'(r4_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv_all[5+T]) begin
      for (int i = 0; i < 3; i++) begin
        hh5_r[i] <= m5[i][MW-1:KL] * m5[i][MW-1:KL];
        hl5_r[i] <= m5[i][MW-1:KL] * m5[i][KL-1:0];
        ll5_r[i] <= m5[i][KL-1:0] * m5[i][KL-1:0];
      end
    end
  end

  // s6: squares
  logic [2*MW-1:0] sq6_r [3];

  always_ff @(posedge clk) begin
    if (adv_all[6+T]) begin
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= ((2*MW)'(hh5_r[i]) << (2*KL)) + ((2*MW)'(hl5_r[i]) << (KL+1))
                  + (2*MW)'(ll5_r[i]);
      end
    end
  end

  // s7: sum of squared residuals
  logic [SW-1:0] sum7_r;

  always_ff @(posedge clk) begin
    if (adv_all[7+T]) begin
      sum7_r <= SW'(sq6_r[0]) + SW'(sq6_r[1]) + SW'(sq6_r[2]);
    end
  end

  // square root cell row, one root bit per cell
  logic [QW+1:0] q_rem  [QW+1];
  logic [QW-1:0] q_root [QW+1];
  logic [SW-1:0] q_src  [QW+1];

  assign q_vld[0]  = post_vld_r[3];
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;
  assign q_src[0]  = sum7_r;

  for (genvar j = 0; j < QW; j++) begin : g_sqrt
    psd_sqrt_cell #(.QW(QW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv_all[8+T+j]),
      .in_vld  (q_vld[j]),
      .rem_in  (q_rem[j]),
      .root_in (q_root[j]),
      .src_in  (q_src[j]),
      .vld_r   (q_vld[j+1]),
      .rem_r   (q_rem[j+1]),
      .root_r  (q_root[j+1]),
      .src_r   (q_src[j+1])
    );
  end

  // output register: scale down, saturate, inlier test
  logic [DXW-1:0]    dx;
  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] dist_r;
  logic              inl_r;

  always_comb begin
    dx       = DXW'(q_root[QW][QW-1:T]);
    dist_nxt = (dx > DXW'(DIST_MAX)) ? DIST_MAX : dx[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv_all[NS-1]) begin
      dist_r <= dist_nxt;
      inl_r  <= dist_nxt <= limit_r;
    end
  end

  assign out_res.valid        = out_vld_r;
  assign out_res.seg_distance = dist_r;
  assign out_res.is_inlier    = inl_r;

  // input stalls only when the first stage is holding a request
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pt.ready |-> pre_vld_r[0])
    else $error("input stalled with empty first stage");

  // divider only runs on a fraction below one
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pre_vld_r[3] && sel3_r == SEL_DIV) |-> (rem3_r < den3_r && den3_r != '0))
    else $error("divider setup out of range");

  // inlier flag agrees with the limit
  a_inlier: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (inl_r == (dist_r <= limit_r)))
    else $error("inlier flag mismatch");

  // a stalled output register keeps its result; the last root cell cannot overwrite it
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res.ready && q_vld[QW]) |-> !adv_all[NS-1])
    else $error("output stage overwritten while full");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Streams points against several segments and compares each distance and
// inlier flag with an exact predictor; both sides stall at random.
// ---------------------------------------------------------------------------
module testbench;
  import psd_pkg::*;

  localparam int LATENCY = 62;
  localparam int N_RANDOM = 1330;

  typedef struct packed {
    logic [17:0] seg_d;
    logic        inl;
  } dist_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psd_pt_if  #(.CW(16)) pt_ch();
  psd_res_if            res_ch();
  psd_cfg_if #(.DW(18)) cfg_ch();

  point_segment_distance_3d i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pt  (pt_ch.snk),
    .out_res(res_ch.src),
    .cfg_wr (cfg_ch.snk)
  );

  always #5 clk = ~clk;

  // segment and limit as the predictor sees them
  logic signed [15:0] seg_a [3];
  logic signed [15:0] seg_b [3];
  logic [17:0]        lim;

  dist_res_t pending_q[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 1'b0;

  // exact distance of a point to the current segment
  function automatic dist_res_t seg_dist(logic signed [15:0] p [3]);
    longint w[3], v[3];
    longint dotp, len2, t, q, rem;
    logic [127:0] acc, rr, c;
    logic [63:0] root;
    dist_res_t res;
    dotp = 0; len2 = 0; acc = '0; root = '0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'(seg_b[i]) - longint'(seg_a[i]);
      w[i] = longint'(p[i]) - longint'(seg_a[i]);
      dotp += w[i] * v[i];
      len2 += v[i] * v[i];
    end
    if (len2 == 0 || dotp <= 0) begin
      t = 0;
    end else if (dotp >= len2) begin
      t = 65536;
    end else begin
      rem = dotp; q = 0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1; q = q << 1;
        if (rem >= len2) begin
          rem -= len2; q |= 1;
        end
      end
      t = q;
    end
    for (int i = 0; i < 3; i++) begin
      rr = 128'(w[i] * 65536 - t * v[i] < 0 ? -(w[i] * 65536 - t * v[i])
                                             : w[i] * 65536 - t * v[i]);
      acc += rr * rr;
    end
    for (int b = 63; b >= 0; b--) begin
      c = 128'(root | (64'd1 << b));
      if (c * c <= acc) root = c[63:0];
    end
    root = root >> 16;
    res.seg_d = (root > 64'(DIST_MAX)) ? DIST_MAX : root[17:0];
    res.inl = res.seg_d <= lim;
    return res;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [17:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    if (idx < REG_END_B_X) seg_a[idx] = val[15:0];
    else if (idx <= REG_END_B_Z) seg_b[idx - REG_END_B_X] = val[15:0];
    else if (idx == REG_INLIER_LIMIT) lim = val;
  endtask

  task automatic set_segment(logic [15:0] ax, ay, az, bx, by, bz, logic [17:0] l);
    write_reg(REG_END_A_X, {2'b0, ax});
    write_reg(REG_END_A_Y, {2'b0, ay});
    write_reg(REG_END_A_Z, {2'b0, az});
    write_reg(REG_END_B_X, {2'b0, bx});
    write_reg(REG_END_B_Y, {2'b0, by});
    write_reg(REG_END_B_Z, {2'b0, bz});
    write_reg(REG_INLIER_LIMIT, l);
    cfg_ch.valid <= 1'b0;
  endtask

  // send one point request; a typed expectation overrides the predictor
  task automatic send_point(logic [15:0] x, y, z, bit typed, dist_res_t exp_res);
    logic signed [15:0] p[3];
    while ($urandom_range(99) < send_idle_pct) begin
      pt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pt_ch.px <= x; pt_ch.py <= y; pt_ch.pz <= z;
    pt_ch.valid <= 1'b1;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
    p[0] = x; p[1] = y; p[2] = z;
    pending_q.insert(pending_q.size(), typed ? exp_res : seg_dist(p));
    @(negedge clk);
  endtask

  task automatic drain;
    pt_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(200)) - 16'd100;
      1: return 16'h8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver with random stalls and a long hold-off window
  always @(negedge clk) begin
    if (!rst_n) res_ch.ready <= 1'b0;
    else res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result dist=%0d inl=%0b", $realtime,
                 res_ch.seg_distance, res_ch.is_inlier);
        errors++;
      end else begin
        dist_res_t e;
        e = pending_q.pop_front();
        if (res_ch.seg_distance !== e.seg_d || res_ch.is_inlier !== e.inl) begin
          $display("%0t: mismatch expected dist=%0d inl=%0b actual dist=%0d inl=%0b",
                   $realtime, e.seg_d, e.inl, res_ch.seg_distance, res_ch.is_inlier);
          errors++;
        end
      end
    end
  end

  // directed points: x, y, z, typed flag, expected distance, expected flag
  typedef struct {
    logic [15:0] x, y, z;
    bit typed;
    logic [17:0] d;
    bit f;
  } point_row_t;

  point_row_t reset_rows[] = '{
    '{16'd0, 16'd0, 16'd0, 1, 18'd0, 1},
    '{16'd3, 16'd4, 16'd0, 1, 18'd5, 0},
    '{16'h7FFF, 16'd0, 16'd0, 1, 18'd32767, 0},
    '{16'h8000, 16'd0, 16'd0, 1, 18'd32768, 0},
    '{16'h8000, 16'h8000, 16'h8000, 1, 18'd56755, 0}
  };
  point_row_t seg_rows[] = '{
    '{16'hFFF6, 16'd3, 16'd0, 0, 0, 0},
    '{16'd500, 16'd3, 16'd4, 0, 0, 0},
    '{16'd1100, 16'd0, 16'd0, 0, 0, 0},
    '{16'd1000, 16'hFFFF, 16'd0, 0, 0, 0},
    '{16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0},
    '{16'h8000, 16'h8000, 16'h8000, 0, 0, 0},
    '{16'd333, 16'd17, 16'hFFEF, 0, 0, 0},
    '{16'h5555, 16'hAAAA, 16'h1234, 0, 0, 0}
  };

  initial begin
    dist_res_t e;
    pt_ch.valid = 1'b0; pt_ch.px = '0; pt_ch.py = '0; pt_ch.pz = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    seg_a = '{0, 0, 0}; seg_b = '{0, 0, 0}; lim = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero-length segment at reset values
    foreach (reset_rows[i]) begin
      e.seg_d = reset_rows[i].d; e.inl = reset_rows[i].f;
      send_point(reset_rows[i].x, reset_rows[i].y, reset_rows[i].z, 1, e);
    end
    drain();

    // axis segment: behind a, inside, beyond b, extremes
    set_segment(16'd0, 16'd0, 16'd0, 16'd1000, 16'd0, 16'd0, 18'd4);
    foreach (seg_rows[i]) send_point(seg_rows[i].x, seg_rows[i].y, seg_rows[i].z, 0, e);
    drain();
    set_segment(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 18'h3FFFF);
    foreach (seg_rows[i]) send_point(seg_rows[i].x, seg_rows[i].y, seg_rows[i].z, 0, e);
    drain();

    // random phases with fresh segments and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 20; recv_idle_pct = 60; end
        1: begin send_idle_pct = 60; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 5)
        set_segment(16'd7, 16'd7, 16'd7, 16'd7, 16'd7, 16'd7, 18'd0);
      else
        set_segment(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                    rnd_coord(), (ph == 0) ? 18'h3FFFF : 18'($urandom_range(40000)));
      if (ph == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < N_RANDOM / 6; n++)
        send_point(rnd_coord(), rnd_coord(), rnd_coord(), 0, e);
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/psd_pkg.sv
rtl/core/psd_if.sv
rtl/core/psd_div_cell.sv
rtl/core/psd_sqrt_cell.sv
rtl/core/point_segment_distance_3d.sv
verif/testbench.sv
